// ===== hw/rtl/mbs_pkg.sv =====
// mbs_pkg: shared widths, codes and types of the masked brush stamp block
// used by every module under hw/rtl, no dependencies of its own
package mbs_pkg;

    // field widths of the input word
    localparam int OP_W       = 2;
    localparam int ORIGIN_W   = 10;
    localparam int VALUE_W    = 8;
    localparam int SLOT_FW    = 3;
    localparam int ROWIDX_W   = 3;
    localparam int ROWBITS_W  = 8;
    localparam int SIZE_W     = 4;
    localparam int COORD_W    = 6;

    // configuration register widths
    localparam int DIM_W      = 7;
    localparam int BCOUNT_W   = 4;

    // internal signed position width (origin plus offsets)
    localparam int POS_W      = 12;

    // apb port
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 2;

    // defaults for the top level parameters
    localparam int MAX_BRUSHES_DEF = 8;
    localparam int BRUSH_SIDE_DEF  = 8;
    localparam int IMAGE_SIDE_DEF  = 64;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // reset values of the registers
    localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 7'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_STAMP = 2'd0;
    localparam logic [OP_W-1:0] OP_ROW   = 2'd1;
    localparam logic [OP_W-1:0] OP_MASK  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASK_ENABLE  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_COUNT  = 2'd3;

    typedef enum logic [2:0] {
        CMD_STAMP,
        CMD_ROW,
        CMD_MASK,
        CMD_ACK,
        CMD_REJECT
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    typedef struct packed {
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic                mask_enable;
        logic [BCOUNT_W-1:0] brush_count;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [SLOT_FW-1:0]     slot;
        logic [ORIGIN_W-1:0]    origin_x;
        logic [ORIGIN_W-1:0]    origin_y;
        logic [VALUE_W-1:0]     paint_value;
        logic [ROWIDX_W-1:0]    row_index;
        logic [ROWBITS_W-1:0]   row_bits;
        logic [SIZE_W-1:0]      slot_width;
        logic [SIZE_W-1:0]      slot_height;
        logic [COORD_W-1:0]     mask_col;
        logic [COORD_W-1:0]     mask_row;
        logic                   mask_value;
    } cmd_t;

    typedef struct packed {
        logic                 write_valid;
        logic [COORD_W-1:0]   write_x;
        logic [COORD_W-1:0]   write_y;
        logic [VALUE_W-1:0]   write_value;
        logic                 stamp_ok;
        logic                 last;
    } res_t;

endpackage

// ===== hw/rtl/mbs_front.sv =====
// mbs_front: accepts input words and classifies them into queue commands
// depends on mbs_pkg
module mbs_front #(
    parameter int MAX_BRUSHES = mbs_pkg::MAX_BRUSHES_DEF,
    parameter int BRUSH_SIDE  = mbs_pkg::BRUSH_SIDE_DEF,
    parameter int IMAGE_SIDE  = mbs_pkg::IMAGE_SIDE_DEF
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mbs_pkg::OP_W-1:0]          s_operation,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_x,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_y,
    input  logic [mbs_pkg::VALUE_W-1:0]       s_paint_value,
    input  logic [mbs_pkg::SLOT_FW-1:0]       s_brush_slot,
    input  logic [mbs_pkg::ROWIDX_W-1:0]      s_row_index,
    input  logic [mbs_pkg::ROWBITS_W-1:0]     s_row_bits,
    input  logic [mbs_pkg::SIZE_W-1:0]        s_slot_width,
    input  logic [mbs_pkg::SIZE_W-1:0]        s_slot_height,
    input  logic [mbs_pkg::COORD_W-1:0]       s_mask_col,
    input  logic [mbs_pkg::COORD_W-1:0]       s_mask_row,
    input  logic                              s_mask_value,
    input  mbs_pkg::cfg_t                     cfg,
    input  logic                              q_full,
    output logic                              q_push,
    output mbs_pkg::cmd_t                     q_cmd
);
    import mbs_pkg::*;

    logic slot_ok;
    logic row_ok;
    logic mask_ok;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign slot_ok = ({1'b0, s_brush_slot} < cfg.brush_count)
                     && (int'(s_brush_slot) < MAX_BRUSHES);
    assign row_ok  = (int'(s_brush_slot) < MAX_BRUSHES) && (int'(s_row_index) < BRUSH_SIDE);
    assign mask_ok = (int'(s_mask_col) < IMAGE_SIDE) && (int'(s_mask_row) < IMAGE_SIDE);

    always_comb begin
        q_cmd.slot        = s_brush_slot;
        q_cmd.origin_x    = s_origin_x;
        q_cmd.origin_y    = s_origin_y;
        q_cmd.paint_value = s_paint_value;
        q_cmd.row_index   = s_row_index;
        q_cmd.row_bits    = s_row_bits;
        // saturate brush size to the brush side
        q_cmd.slot_width  = (int'(s_slot_width) > BRUSH_SIDE) ? SIZE_W'(BRUSH_SIDE)
                                                              : s_slot_width;
        q_cmd.slot_height = (int'(s_slot_height) > BRUSH_SIDE) ? SIZE_W'(BRUSH_SIDE)
                                                               : s_slot_height;
        q_cmd.mask_col    = s_mask_col;
        q_cmd.mask_row    = s_mask_row;
        q_cmd.mask_value  = s_mask_value;
        case (s_operation)
            OP_STAMP: q_cmd.kind = slot_ok ? CMD_STAMP : CMD_REJECT;
            OP_ROW:   q_cmd.kind = row_ok  ? CMD_ROW   : CMD_ACK;
            OP_MASK:  q_cmd.kind = mask_ok ? CMD_MASK  : CMD_ACK;
            default:  q_cmd.kind = CMD_REJECT;
        endcase
    end

endmodule

// ===== hw/rtl/mbs_queue.sv =====
// mbs_queue: short command queue between the front and the back
// depends on mbs_pkg
module mbs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mbs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output mbs_pkg::cmd_t head_cmd
);
    import mbs_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/mbs_back.sv =====
// mbs_back: brush and mask stores, stamp walker and result register
// depends on mbs_pkg
module mbs_back #(
    parameter int MAX_BRUSHES = mbs_pkg::MAX_BRUSHES_DEF,
    parameter int BRUSH_SIDE  = mbs_pkg::BRUSH_SIDE_DEF,
    parameter int IMAGE_SIDE  = mbs_pkg::IMAGE_SIDE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mbs_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  mbs_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mbs_pkg::res_t m_res
);
    import mbs_pkg::*;

    localparam int SLOT_W     = (MAX_BRUSHES > 1) ? $clog2(MAX_BRUSHES) : 1;
    localparam int CNT_W      = (BRUSH_SIDE > 1) ? $clog2(BRUSH_SIDE) : 1;
    localparam int ROW_DEPTH  = MAX_BRUSHES * BRUSH_SIDE;
    localparam int ROW_AW     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int MASK_DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int MASK_AW    = $clog2(MASK_DEPTH);

    // stores
    logic [ROWBITS_W-1:0] brush_rows_reg [ROW_DEPTH];
    logic [SIZE_W-1:0]    brush_w_reg    [MAX_BRUSHES];
    logic [SIZE_W-1:0]    brush_h_reg    [MAX_BRUSHES];
    logic                 mask_plane_reg [MASK_DEPTH];

    back_state_t state_reg, state_next;

    // walk counter stage
    logic                s0_act_reg;
    logic [CNT_W-1:0]    cnt_i_reg, cnt_j_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SIZE_W-1:0]   w_reg, h_reg;
    logic [POS_W-1:0]    base_x_reg, base_y_reg;
    logic [VALUE_W-1:0]  value_reg;

    // brush row stage
    logic                 s1_vld_reg;
    logic [ROWBITS_W-1:0] row_q_reg;
    logic [CNT_W-1:0]     s1_i_reg, s1_j_reg;

    // mask stage
    logic               s2_vld_reg;
    logic               mask_q_reg;
    logic [COORD_W-1:0] s2_x_reg, s2_y_reg;

    // held write, sent once the next one or the end is known
    logic               pend_vld_reg;
    logic [COORD_W-1:0] pend_x_reg, pend_y_reg;

    logic m_valid_reg;
    res_t res_reg;

    logic               out_free;
    logic               busy;
    logic               i_end, j_end;
    logic [SIZE_W-1:0]  start_w, start_h;
    logic [DIM_W-1:0]   iw, ih;
    logic [POS_W-1:0]   px, py;
    logic               in_bounds;
    logic               brush_bit;
    logic               hit;
    logic [ROW_AW-1:0]  row_rd_addr, row_wr_addr;
    logic [MASK_AW-1:0] mask_rd_addr, mask_wr_addr;

    logic start, adv, fin, emit, row_we, mask_we, row_re;
    res_t emit_res;

    assign out_free = !m_valid_reg || m_ready;
    assign busy     = s0_act_reg || s1_vld_reg || s2_vld_reg;
    assign i_end    = (SIZE_W'(cnt_i_reg) == w_reg - SIZE_W'(1));
    assign j_end    = (SIZE_W'(cnt_j_reg) == h_reg - SIZE_W'(1));
    assign start_w  = brush_w_reg[SLOT_W'(q_cmd.slot)];
    assign start_h  = brush_h_reg[SLOT_W'(q_cmd.slot)];

    assign iw = (int'(cfg.image_width) > IMAGE_SIDE) ? DIM_W'(IMAGE_SIDE) : cfg.image_width;
    assign ih = (int'(cfg.image_height) > IMAGE_SIDE) ? DIM_W'(IMAGE_SIDE) : cfg.image_height;

    assign px = base_x_reg + POS_W'(s1_i_reg);
    assign py = base_y_reg + POS_W'(s1_j_reg);
    assign in_bounds = !px[POS_W-1] && !py[POS_W-1]
                       && (px[POS_W-2:0] < (POS_W-1)'(iw))
                       && (py[POS_W-2:0] < (POS_W-1)'(ih));
    assign brush_bit = row_q_reg[s1_i_reg];
    assign hit       = s2_vld_reg && (!cfg.mask_enable || mask_q_reg);

    assign row_rd_addr  = ROW_AW'(int'(slot_reg) * BRUSH_SIDE + int'(cnt_j_reg));
    assign row_wr_addr  = ROW_AW'(int'(q_cmd.slot) * BRUSH_SIDE + int'(q_cmd.row_index));
    assign mask_rd_addr = in_bounds
                          ? MASK_AW'(int'(py[COORD_W-1:0]) * IMAGE_SIDE
                                     + int'(px[COORD_W-1:0]))
                          : '0;
    assign mask_wr_addr = MASK_AW'(int'(q_cmd.mask_row) * IMAGE_SIDE + int'(q_cmd.mask_col));
    assign row_re       = adv && s0_act_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (start) state_next = BK_WALK;
            BK_WALK: if (fin)   state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        start    = 1'b0;
        adv      = 1'b0;
        fin      = 1'b0;
        emit     = 1'b0;
        row_we   = 1'b0;
        mask_we  = 1'b0;
        emit_res = '0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop             = 1'b1;
                    emit              = 1'b1;
                    emit_res.stamp_ok = 1'b1;
                    emit_res.last     = 1'b1;
                    case (q_cmd.kind)
                        CMD_STAMP: begin
                            start = 1'b1;
                            emit  = 1'b0;
                        end
                        CMD_ROW:    row_we = 1'b1;
                        CMD_MASK:   mask_we = 1'b1;
                        CMD_ACK:    ;
                        CMD_REJECT: emit_res.stamp_ok = 1'b0;
                        default:    emit_res.stamp_ok = 1'b0;
                    endcase
                end
            end
            BK_WALK: begin
                adv = out_free;
                emit_res.write_valid = 1'b1;
                emit_res.write_x     = pend_x_reg;
                emit_res.write_y     = pend_y_reg;
                emit_res.write_value = value_reg;
                emit_res.stamp_ok    = 1'b1;
                if (busy) begin
                    // a new hit pushes the held one out, not yet last
                    emit = out_free && hit && pend_vld_reg;
                end else if (out_free) begin
                    fin           = 1'b1;
                    emit          = 1'b1;
                    emit_res.last = 1'b1;
                    if (!pend_vld_reg) begin
                        emit_res.write_valid = 1'b0;
                        emit_res.write_x     = '0;
                        emit_res.write_y     = '0;
                        emit_res.write_value = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            s0_act_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start) begin
                s0_act_reg <= (start_w != '0) && (start_h != '0);
            end else if (row_re && i_end && j_end) begin
                s0_act_reg <= 1'b0;
            end
            if (adv) begin
                s1_vld_reg <= s0_act_reg;
                s2_vld_reg <= s1_vld_reg && brush_bit && in_bounds;
            end
            if (fin) begin
                pend_vld_reg <= 1'b0;
            end else if (adv && hit) begin
                pend_vld_reg <= 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            slot_reg   <= SLOT_W'(q_cmd.slot);
            w_reg      <= start_w;
            h_reg      <= start_h;
            base_x_reg <= {{(POS_W-ORIGIN_W){q_cmd.origin_x[ORIGIN_W-1]}}, q_cmd.origin_x}
                          - POS_W'(start_w >> 1);
            base_y_reg <= {{(POS_W-ORIGIN_W){q_cmd.origin_y[ORIGIN_W-1]}}, q_cmd.origin_y}
                          - POS_W'(start_h >> 1);
            value_reg  <= q_cmd.paint_value;
            cnt_i_reg  <= '0;
            cnt_j_reg  <= '0;
        end else if (row_re) begin
            if (i_end) begin
                cnt_i_reg <= '0;
                cnt_j_reg <= cnt_j_reg + CNT_W'(1);
            end else begin
                cnt_i_reg <= cnt_i_reg + CNT_W'(1);
            end
        end
        if (row_re) begin
            s1_i_reg <= cnt_i_reg;
            s1_j_reg <= cnt_j_reg;
        end
        if (adv) begin
            s2_x_reg <= px[COORD_W-1:0];
            s2_y_reg <= py[COORD_W-1:0];
        end
        if (adv && hit) begin
            pend_x_reg <= s2_x_reg;
            pend_y_reg <= s2_y_reg;
        end
        if (emit) begin
            res_reg <= emit_res;
        end
    end

    // brush size table
    always_ff @(posedge aclk) begin
        if (row_we) begin
            brush_w_reg[SLOT_W'(q_cmd.slot)] <= q_cmd.slot_width;
            brush_h_reg[SLOT_W'(q_cmd.slot)] <= q_cmd.slot_height;
        end
    end

    // brush row memory, registered read
    always_ff @(posedge aclk) begin
        if (row_we) begin
            brush_rows_reg[row_wr_addr] <= q_cmd.row_bits;
        end
        if (row_re) begin
            row_q_reg <= brush_rows_reg[row_rd_addr];
        end
    end

    // mask plane memory, registered read
    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_plane_reg[mask_wr_addr] <= q_cmd.mask_value;
        end
        if (adv) begin
            mask_q_reg <= mask_plane_reg[mask_rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== hw/rtl/masked_brush_stamp_top.sv =====
// masked_brush_stamp_top: top level of the masked brush stamp block
// holds the apb registers and ties together mbs_front, mbs_queue and mbs_back (mbs_pkg)
//
// A stamp word walks one brush slot in row-major order, one brush pixel per clock
// while the result side is free, and sends one result word per pixel write that lands
// inside the image and, with the mask on, on a set mask bit; the final word carries
// last, and a stamp that writes nothing gives one empty word with stamp_ok set. A bad
// slot or an unknown operation gives one word with stamp_ok clear. Row and mask loads
// store into the brush row memory and the mask plane and give one acknowledge word
// each. The input side accepts a word per clock while the queue has room, into a
// two-word command queue; the back end handles one command at a time and takes no
// new one until a stamp's walk is done. Result back-pressure stalls the walker but
// not the queue. Stores are not cleared at reset: load a slot or a mask bit before
// it is used.
module masked_brush_stamp_top #(
    parameter int MAX_BRUSHES = mbs_pkg::MAX_BRUSHES_DEF,
    parameter int BRUSH_SIDE  = mbs_pkg::BRUSH_SIDE_DEF,
    parameter int IMAGE_SIDE  = mbs_pkg::IMAGE_SIDE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mbs_pkg::OP_W-1:0]            s_operation,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_x,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_y,
    input  logic [mbs_pkg::VALUE_W-1:0]         s_paint_value,
    input  logic [mbs_pkg::SLOT_FW-1:0]         s_brush_slot,
    input  logic [mbs_pkg::ROWIDX_W-1:0]        s_row_index,
    input  logic [mbs_pkg::ROWBITS_W-1:0]       s_row_bits,
    input  logic [mbs_pkg::SIZE_W-1:0]          s_slot_width,
    input  logic [mbs_pkg::SIZE_W-1:0]          s_slot_height,
    input  logic [mbs_pkg::COORD_W-1:0]         s_mask_col,
    input  logic [mbs_pkg::COORD_W-1:0]         s_mask_row,
    input  logic                                s_mask_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_valid,
    output logic [mbs_pkg::COORD_W-1:0]         m_write_x,
    output logic [mbs_pkg::COORD_W-1:0]         m_write_y,
    output logic [mbs_pkg::VALUE_W-1:0]         m_write_value,
    output logic                                m_stamp_ok,
    output logic                                m_last,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbs_pkg::APB_AW-1:0]          paddr,
    input  logic [mbs_pkg::APB_DW-1:0]          pwdata,
    output logic [mbs_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import mbs_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;
    logic                mask_enable_reg;
    logic [BCOUNT_W-1:0] brush_count_reg;

    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    cfg_t                 cfg;

    // front to queue, queue to back
    logic q_full, q_push, q_pop, q_not_empty;
    cmd_t push_cmd, head_cmd;
    res_t m_res;

    // registers are 4 bytes apart, the low address bits do not decode
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            mask_enable_reg  <= 1'b0;
            brush_count_reg  <= '0;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_MASK_ENABLE:  mask_enable_reg  <= pwdata[0];
                REG_BRUSH_COUNT:  brush_count_reg  <= pwdata[BCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_reg);
            REG_MASK_ENABLE:  prdata = APB_DW'(mask_enable_reg);
            REG_BRUSH_COUNT:  prdata = APB_DW'(brush_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        cfg.image_width  = image_width_reg;
        cfg.image_height = image_height_reg;
        cfg.mask_enable  = mask_enable_reg;
        cfg.brush_count  = brush_count_reg;
    end

    // front: takes a word whenever the queue has room and tags it
    mbs_front #(
        .MAX_BRUSHES (MAX_BRUSHES),
        .BRUSH_SIDE  (BRUSH_SIDE),
        .IMAGE_SIDE  (IMAGE_SIDE)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_origin_x    (s_origin_x),
        .s_origin_y    (s_origin_y),
        .s_paint_value (s_paint_value),
        .s_brush_slot  (s_brush_slot),
        .s_row_index   (s_row_index),
        .s_row_bits    (s_row_bits),
        .s_slot_width  (s_slot_width),
        .s_slot_height (s_slot_height),
        .s_mask_col    (s_mask_col),
        .s_mask_row    (s_mask_row),
        .s_mask_value  (s_mask_value),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // commands wait here so the input side keeps moving during a stamp
    mbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // back: loads, stamp walk and the result register
    mbs_back #(
        .MAX_BRUSHES (MAX_BRUSHES),
        .BRUSH_SIDE  (BRUSH_SIDE),
        .IMAGE_SIDE  (IMAGE_SIDE)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_not_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_write_valid = m_res.write_valid;
    assign m_write_x     = m_res.write_x;
    assign m_write_y     = m_res.write_y;
    assign m_write_value = m_res.write_value;
    assign m_stamp_ok    = m_res.stamp_ok;
    assign m_last        = m_res.last;

endmodule

// ===== hw/rtl/mbs_checker.sv =====
// mbs_port_checks: port-level checks of the result channel of masked_brush_stamp_top
// bound to the top level at the end of this file, depends on mbs_pkg
module mbs_port_checks (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_write_valid,
    input logic [mbs_pkg::COORD_W-1:0] m_write_x,
    input logic [mbs_pkg::COORD_W-1:0] m_write_y,
    input logic                        m_stamp_ok,
    input logic                        m_last
);
    import mbs_pkg::*;

    // no result word survives a reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a pixel write only comes from a good stamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_valid |-> m_stamp_ok)
        else $error("pixel write without stamp_ok");

    // words without a write are always the single answer to their input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |-> m_last)
        else $error("non-write word without last");

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=>
            m_valid && $stable(m_write_x) && $stable(m_write_y) && $stable(m_last))
        else $error("stalled result word changed");

endmodule

bind masked_brush_stamp_top mbs_port_checks u_mbs_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_write_valid (m_write_valid),
    .m_write_x     (m_write_x),
    .m_write_y     (m_write_y),
    .m_stamp_ok    (m_stamp_ok),
    .m_last        (m_last)
);

// ===== tb/mbs_checker.sv =====
`timescale 1ns / 100ps
// mbs_checker: watches the word channels and register port of masked_brush_stamp_top,
// predicts every result word from its own copy of brushes, mask and registers
// and compares; depends on mbs_pkg for widths, codes and the result word type
module mbs_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [mbs_pkg::OP_W-1:0]            s_operation,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_x,
    input  logic signed [mbs_pkg::ORIGIN_W-1:0] s_origin_y,
    input  logic [mbs_pkg::VALUE_W-1:0]         s_paint_value,
    input  logic [mbs_pkg::SLOT_FW-1:0]         s_brush_slot,
    input  logic [mbs_pkg::ROWIDX_W-1:0]        s_row_index,
    input  logic [mbs_pkg::ROWBITS_W-1:0]       s_row_bits,
    input  logic [mbs_pkg::SIZE_W-1:0]          s_slot_width,
    input  logic [mbs_pkg::SIZE_W-1:0]          s_slot_height,
    input  logic [mbs_pkg::COORD_W-1:0]         s_mask_col,
    input  logic [mbs_pkg::COORD_W-1:0]         s_mask_row,
    input  logic                                s_mask_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_write_valid,
    input  logic [mbs_pkg::COORD_W-1:0]         m_write_x,
    input  logic [mbs_pkg::COORD_W-1:0]         m_write_y,
    input  logic [mbs_pkg::VALUE_W-1:0]         m_write_value,
    input  logic                                m_stamp_ok,
    input  logic                                m_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbs_pkg::APB_AW-1:0]          paddr,
    input  logic [mbs_pkg::APB_DW-1:0]          pwdata,
    input  logic                                pready,
    output int                                  pending,
    output int                                  fault_count,
    output int                                  words_checked,
    output int                                  pixel_writes
);
    import mbs_pkg::*;

    localparam int SIDE   = IMAGE_SIDE_DEF;
    localparam int BSIDE  = BRUSH_SIDE_DEF;
    localparam int NBRUSH = MAX_BRUSHES_DEF;

    logic [ROWBITS_W-1:0] brush_row_mem [NBRUSH*BSIDE];
    logic [SIZE_W-1:0]    brush_w_mem [NBRUSH];
    logic [SIZE_W-1:0]    brush_h_mem [NBRUSH];
    logic                 mask_mem [SIDE*SIDE];

    logic [DIM_W-1:0]     img_w_reg;
    logic [DIM_W-1:0]     img_h_reg;
    logic                 mask_en_reg;
    logic [BCOUNT_W-1:0]  brush_cnt_reg;

    res_t due_writes [$];

    initial begin
        pending       = 0;
        fault_count   = 0;
        words_checked = 0;
        pixel_writes  = 0;
        foreach (brush_row_mem[k]) brush_row_mem[k] = '0;
        foreach (brush_w_mem[k]) brush_w_mem[k] = '0;
        foreach (brush_h_mem[k]) brush_h_mem[k] = '0;
        foreach (mask_mem[k]) mask_mem[k] = 1'b0;
    end

    function automatic res_t make_word(input logic wv, input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [VALUE_W-1:0] val,
                                       input logic ok, input logic lst);
        res_t word;
        word.write_valid = wv;
        word.write_x     = x;
        word.write_y     = y;
        word.write_value = val;
        word.stamp_ok    = ok;
        word.last        = lst;
        return word;
    endfunction

    // appends one awaited result word at the tail
    function automatic void add_due(input res_t word);
        due_writes = {due_writes, word};
    endfunction

    // sizes above the brush side saturate when stored
    function automatic logic [SIZE_W-1:0] clip_side(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] full;
        full = SIZE_W'(BSIDE);
        return (v > full) ? full : v;
    endfunction

    // works out the result words of one accepted input word and queues them
    task automatic derive_writes();
        int ox, oy, iw, ih, w, h, px, py, found, base;
        logic [ROWBITS_W-1:0] bits;
        res_t held;
        ox = int'(s_origin_x);
        oy = int'(s_origin_y);
        base = int'(s_brush_slot) * BSIDE;
        case (s_operation)
            OP_ROW: begin
                // slot and row fields cannot leave the table at these widths
                brush_row_mem[base + int'(s_row_index)] = s_row_bits;
                brush_w_mem[s_brush_slot] = clip_side(s_slot_width);
                brush_h_mem[s_brush_slot] = clip_side(s_slot_height);
                add_due(make_word(1'b0, '0, '0, '0, 1'b1, 1'b1));
            end
            OP_MASK: begin
                mask_mem[int'(s_mask_row) * SIDE + int'(s_mask_col)] = s_mask_value;
                add_due(make_word(1'b0, '0, '0, '0, 1'b1, 1'b1));
            end
            OP_STAMP: begin
                if (s_brush_slot >= brush_cnt_reg) begin
                    add_due(make_word(1'b0, '0, '0, '0, 1'b0, 1'b1));
                end else begin
                    iw = (img_w_reg > SIDE) ? SIDE : int'(img_w_reg);
                    ih = (img_h_reg > SIDE) ? SIDE : int'(img_h_reg);
                    w = int'(brush_w_mem[s_brush_slot]);
                    h = int'(brush_h_mem[s_brush_slot]);
                    found = 0;
                    for (int j = 0; j < h; j++) begin
                        bits = brush_row_mem[base + j];
                        for (int i = 0; i < w; i++) begin
                            px = ox + i - w / 2;
                            py = oy + j - h / 2;
                            if (bits[i] && px >= 0 && py >= 0 && px < iw && py < ih &&
                                (!mask_en_reg || mask_mem[py * SIDE + px])) begin
                                if (found > 0) begin
                                    add_due(held);
                                end
                                held = make_word(1'b1, px[COORD_W-1:0], py[COORD_W-1:0],
                                                 s_paint_value, 1'b1, 1'b0);
                                found++;
                            end
                        end
                    end
                    if (found == 0) begin
                        add_due(make_word(1'b0, '0, '0, '0, 1'b1, 1'b1));
                    end else begin
                        held.last = 1'b1;
                        add_due(held);
                    end
                end
            end
            default: begin
                add_due(make_word(1'b0, '0, '0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            due_writes.delete();
            img_w_reg     = IMAGE_WIDTH_RST;
            img_h_reg     = IMAGE_HEIGHT_RST;
            mask_en_reg   = 1'b0;
            brush_cnt_reg = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[REG_IDX_W+1:2])
                    REG_IMAGE_WIDTH:  img_w_reg     = pwdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: img_h_reg     = pwdata[DIM_W-1:0];
                    REG_MASK_ENABLE:  mask_en_reg   = pwdata[0];
                    REG_BRUSH_COUNT:  brush_cnt_reg = pwdata[BCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                derive_writes();
            end
            if (m_valid && m_ready) begin
                got = make_word(m_write_valid, m_write_x, m_write_y, m_write_value,
                                m_stamp_ok, m_last);
                words_checked++;
                if (m_write_valid === 1'b1) begin
                    pixel_writes++;
                end
                if (due_writes.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%t: result word with nothing awaited", $time);
                        $display("  actual   wv=%b x=%0d y=%0d val=%0d ok=%b last=%b",
                                 got.write_valid, got.write_x, got.write_y,
                                 got.write_value, got.stamp_ok, got.last);
                    end
                end else begin
                    want = due_writes.pop_front();
                    if (got.write_valid !== want.write_valid || got.write_x !== want.write_x ||
                        got.write_y !== want.write_y || got.write_value !== want.write_value ||
                        got.stamp_ok !== want.stamp_ok || got.last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("%t: result word %0d differs", $time, words_checked);
                            $display("  expected wv=%b x=%0d y=%0d val=%0d ok=%b last=%b",
                                     want.write_valid, want.write_x, want.write_y,
                                     want.write_value, want.stamp_ok, want.last);
                            $display("  actual   wv=%b x=%0d y=%0d val=%0d ok=%b last=%b",
                                     got.write_valid, got.write_x, got.write_y,
                                     got.write_value, got.stamp_ok, got.last);
                        end
                    end
                end
            end
        end
        pending = due_writes.size();
    end

endmodule

// ===== tb/masked_brush_stamp_top_tb.sv =====
`timescale 1ns / 100ps
// masked_brush_stamp_top_tb: drives input words and register writes into
// masked_brush_stamp_top and gives the verdict; mbs_checker does all checking
// depends on mbs_pkg, masked_brush_stamp_top and mbs_checker
module masked_brush_stamp_top_tb;
    import mbs_pkg::*;

    // the fourth operation code has no name in the package, it must be rejected
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SIDE    = IMAGE_SIDE_DEF;
    localparam int BSIDE   = BRUSH_SIDE_DEF;
    localparam int NPHASE  = 10;
    localparam int PER_PHASE = 36;

    // one input word as the generator sees it
    typedef struct {
        logic [OP_W-1:0]            op;
        logic signed [ORIGIN_W-1:0] ox;
        logic signed [ORIGIN_W-1:0] oy;
        logic [VALUE_W-1:0]         value;
        logic [SLOT_FW-1:0]         slot;
        logic [ROWIDX_W-1:0]        row;
        logic [ROWBITS_W-1:0]       bits;
        logic [SIZE_W-1:0]          sw;
        logic [SIZE_W-1:0]          sh;
        logic [COORD_W-1:0]         mcol;
        logic [COORD_W-1:0]         mrow;
        logic                       mval;
    } cmd_word_t;

    // all block inputs start known
    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_valid       = 1'b0;
    logic [OP_W-1:0]             s_operation   = '0;
    logic signed [ORIGIN_W-1:0]  s_origin_x    = '0;
    logic signed [ORIGIN_W-1:0]  s_origin_y    = '0;
    logic [VALUE_W-1:0]          s_paint_value = '0;
    logic [SLOT_FW-1:0]          s_brush_slot  = '0;
    logic [ROWIDX_W-1:0]         s_row_index   = '0;
    logic [ROWBITS_W-1:0]        s_row_bits    = '0;
    logic [SIZE_W-1:0]           s_slot_width  = '0;
    logic [SIZE_W-1:0]           s_slot_height = '0;
    logic [COORD_W-1:0]          s_mask_col    = '0;
    logic [COORD_W-1:0]          s_mask_row    = '0;
    logic                        s_mask_value  = 1'b0;
    logic                        m_ready       = 1'b0;
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [APB_AW-1:0]           paddr         = '0;
    logic [APB_DW-1:0]           pwdata        = '0;

    logic                        s_ready;
    logic                        m_valid;
    logic                        m_write_valid;
    logic [COORD_W-1:0]          m_write_x;
    logic [COORD_W-1:0]          m_write_y;
    logic [VALUE_W-1:0]          m_write_value;
    logic                        m_stamp_ok;
    logic                        m_last;
    logic [APB_DW-1:0]           prdata;
    logic                        pready;

    // from the checker
    int pending;
    int fault_count;
    int words_checked;
    int pixel_writes;

    // generator's view of what the block holds, so that a stamp never reads
    // a brush row, brush size or mask bit that was never loaded
    bit row_loaded [BSIDE*MAX_BRUSHES_DEF];
    bit size_loaded [MAX_BRUSHES_DEF];
    int width_kept [MAX_BRUSHES_DEF];
    int height_kept [MAX_BRUSHES_DEF];
    bit mask_loaded [SIDE*SIDE];

    // register settings currently in force
    int cfg_w     = 64;
    int cfg_h     = 64;
    int cfg_mask  = 0;
    int cfg_count = 0;

    // with calm set, neither side idles
    bit calm = 1'b0;

    int words_sent    = 0;
    int stamps_sent   = 0;
    int loads_sent    = 0;
    int unknown_sent  = 0;
    int settings_used = 0;

    // random phases: image width, image height, mask enable, brush count
    int phase_w     [NPHASE] = '{64, 1, 8, 127, 0, 5, 64, 17, 4, 64};
    int phase_h     [NPHASE] = '{64, 1, 8, 127, 5, 12, 1, 33, 4, 64};
    int phase_mask  [NPHASE] = '{0, 0, 1, 0, 0, 1, 0, 0, 1, 0};
    int phase_count [NPHASE] = '{8, 8, 8, 15, 4, 3, 0, 6, 8, 9};

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    masked_brush_stamp_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_origin_x    (s_origin_x),
        .s_origin_y    (s_origin_y),
        .s_paint_value (s_paint_value),
        .s_brush_slot  (s_brush_slot),
        .s_row_index   (s_row_index),
        .s_row_bits    (s_row_bits),
        .s_slot_width  (s_slot_width),
        .s_slot_height (s_slot_height),
        .s_mask_col    (s_mask_col),
        .s_mask_row    (s_mask_row),
        .s_mask_value  (s_mask_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_valid (m_write_valid),
        .m_write_x     (m_write_x),
        .m_write_y     (m_write_y),
        .m_write_value (m_write_value),
        .m_stamp_ok    (m_stamp_ok),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mbs_checker u_checker (.*);

    // stored brush sizes saturate at the brush side
    function automatic int side_clamp(input int v);
        return (v > BSIDE) ? BSIDE : v;
    endfunction

    // every field random, so every input bit toggles whatever the operation
    function automatic cmd_word_t random_word();
        cmd_word_t wd;
        logic [31:0] r0, r1, r2;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        wd.op    = r0[1:0];
        wd.ox    = r0[11:2];
        wd.oy    = r0[21:12];
        wd.slot  = r0[24:22];
        wd.row   = r0[27:25];
        wd.sw    = r0[31:28];
        wd.value = r1[7:0];
        wd.bits  = r1[15:8];
        wd.sh    = r1[19:16];
        wd.mcol  = r1[25:20];
        wd.mrow  = r1[31:26];
        wd.mval  = r2[0];
        return wd;
    endfunction

    // brush sizes: mostly legal, now and then anything the 4 bits allow
    function automatic int pick_side();
        if ($urandom_range(0, 6) == 0) begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(1, BSIDE);
    endfunction

    // origins mostly near the image so that stamps clip at every edge,
    // sometimes anywhere in the 10-bit range
    function automatic int pick_origin(input int dim);
        logic [31:0] r;
        logic signed [ORIGIN_W-1:0] raw;
        int span;
        span = (dim > SIDE) ? SIDE : dim;
        if ($urandom_range(0, 4) == 0) begin
            r = $urandom;
            raw = r[ORIGIN_W-1:0];
            return raw;
        end
        return int'($urandom_range(0, span + 15)) - 8;
    endfunction

    // one word through the input handshake, after a random idle gap;
    // valid stays high straight into the next word when the gap is zero
    task automatic push_word(input cmd_word_t wd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= wd.op;
        s_origin_x    <= wd.ox;
        s_origin_y    <= wd.oy;
        s_paint_value <= wd.value;
        s_brush_slot  <= wd.slot;
        s_row_index   <= wd.row;
        s_row_bits    <= wd.bits;
        s_slot_width  <= wd.sw;
        s_slot_height <= wd.sh;
        s_mask_col    <= wd.mcol;
        s_mask_row    <= wd.mrow;
        s_mask_value  <= wd.mval;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        // keep track of what the block now holds
        case (wd.op)
            OP_STAMP: stamps_sent++;
            OP_ROW: begin
                loads_sent++;
                row_loaded[int'(wd.slot) * BSIDE + int'(wd.row)] = 1'b1;
                size_loaded[wd.slot] = 1'b1;
                width_kept[wd.slot]  = side_clamp(int'(wd.sw));
                height_kept[wd.slot] = side_clamp(int'(wd.sh));
            end
            OP_MASK: begin
                loads_sent++;
                mask_loaded[int'(wd.mrow) * SIDE + int'(wd.mcol)] = 1'b1;
            end
            default: unknown_sent++;
        endcase
    endtask

    // sender goes quiet until every awaited result word has arrived;
    // pending is looked at on the falling edge, clear of the checker's update
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle, then back to idle;
    // pready is always high
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // registers change only with the block idle
    task automatic apply_settings(input int w, input int h, input int msk, input int cnt);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_MASK_ENABLE, msk);
        write_reg(REG_BRUSH_COUNT, cnt);
        cfg_w = w;
        cfg_h = h;
        cfg_mask = msk;
        cfg_count = cnt;
        settings_used++;
    endtask

    // loads a whole brush: every row the stored height covers, at least one
    // so that the sizes get stored; fill < 0 gives random rows
    task automatic define_brush(input int slot, input int w, input int h, input int fill);
        cmd_word_t wd;
        int rows;
        rows = (side_clamp(h) == 0) ? 1 : side_clamp(h);
        for (int r = 0; r < rows; r++) begin
            wd = random_word();
            wd.op   = OP_ROW;
            wd.slot = slot[SLOT_FW-1:0];
            wd.row  = r[ROWIDX_W-1:0];
            wd.sw   = w[SIZE_W-1:0];
            wd.sh   = h[SIZE_W-1:0];
            if (fill >= 0) begin
                wd.bits = fill[ROWBITS_W-1:0];
            end
            push_word(wd);
        end
    endtask

    // a stamp preceded by whatever loads it needs: missing rows of a valid
    // slot and, with the mask on, every missing mask bit of the footprint inside the image
    task automatic stamp_at(input int slot, input int ox, input int oy, input int val);
        cmd_word_t wd;
        int iw, ih, px, py;
        if (slot < cfg_count) begin
            if (!size_loaded[slot]) begin
                define_brush(slot, $urandom_range(1, BSIDE), $urandom_range(1, BSIDE), -1);
            end
            for (int r = 0; r < height_kept[slot]; r++) begin
                if (!row_loaded[slot * BSIDE + r]) begin
                    wd = random_word();
                    wd.op   = OP_ROW;
                    wd.slot = slot[SLOT_FW-1:0];
                    wd.row  = r[ROWIDX_W-1:0];
                    wd.sw   = width_kept[slot][SIZE_W-1:0];
                    wd.sh   = height_kept[slot][SIZE_W-1:0];
                    push_word(wd);
                end
            end
            if (cfg_mask != 0) begin
                iw = (cfg_w > SIDE) ? SIDE : cfg_w;
                ih = (cfg_h > SIDE) ? SIDE : cfg_h;
                for (int j = 0; j < height_kept[slot]; j++) begin
                    for (int i = 0; i < width_kept[slot]; i++) begin
                        px = ox + i - width_kept[slot] / 2;
                        py = oy + j - height_kept[slot] / 2;
                        if (px >= 0 && py >= 0 && px < iw && py < ih &&
                            !mask_loaded[py * SIDE + px]) begin
                            // mostly open so that masked stamps still paint
                            wd = random_word();
                            wd.op   = OP_MASK;
                            wd.mcol = px[COORD_W-1:0];
                            wd.mrow = py[COORD_W-1:0];
                            wd.mval = ($urandom_range(0, 3) != 0);
                            push_word(wd);
                        end
                    end
                end
            end
        end
        wd = random_word();
        wd.op    = OP_STAMP;
        wd.slot  = slot[SLOT_FW-1:0];
        wd.ox    = ox[ORIGIN_W-1:0];
        wd.oy    = oy[ORIGIN_W-1:0];
        wd.value = val[VALUE_W-1:0];
        push_word(wd);
    endtask

    // result side: random stall before every word, none while calm
    initial begin
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // stimulus and verdict
    initial begin
        cmd_word_t wd;
        int phase_stop;
        int pick;
        int slot;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: brush count 0, so any stamp names a bad slot
        wd = random_word();
        wd.op = OP_STAMP;
        push_word(wd);
        // unknown operation gets rejected
        wd = random_word();
        wd.op = OP_UNUSED;
        push_word(wd);
        // mask loads at opposite corners
        wd = random_word();
        wd.op = OP_MASK;
        wd.mcol = '0;
        wd.mrow = '0;
        wd.mval = 1'b1;
        push_word(wd);
        wd.mcol = '1;
        wd.mrow = '1;
        wd.mval = 1'b0;
        push_word(wd);

        apply_settings(64, 64, 0, 8);
        // full 8x8 brush clipped at the top-left and bottom-right corners
        define_brush(0, 8, 8, 8'hff);
        stamp_at(0, 0, 0, 8'hff);
        stamp_at(0, 63, 63, 8'h00);
        // origins at the ends of the range land nowhere: empty success word
        stamp_at(0, -512, -512, 8'h81);
        stamp_at(0, 511, 511, 8'h7e);
        // row bits past the brush width are ignored
        define_brush(1, 3, 1, 8'hff);
        stamp_at(1, 32, 40, 8'h5a);
        // zero width gives an empty brush
        define_brush(2, 0, 2, 8'hff);
        stamp_at(2, 10, 10, 8'h33);
        // oversized width saturates to the brush side
        define_brush(3, 15, 1, 8'hff);
        stamp_at(3, 20, 20, 8'hc3);

        // random phases over a spread of settings, extremes included
        for (int p = 0; p < NPHASE; p++) begin
            apply_settings(phase_w[p], phase_h[p], phase_mask[p], phase_count[p]);
            calm = ($urandom_range(0, 3) == 0);
            phase_stop = words_sent + PER_PHASE;
            while (words_sent < phase_stop) begin
                pick = $urandom_range(0, 99);
                slot = $urandom_range(0, MAX_BRUSHES_DEF - 1);
                if (pick < 50) begin
                    stamp_at(slot, pick_origin(cfg_w), pick_origin(cfg_h),
                             $urandom_range(0, 255));
                end else if (pick < 62) begin
                    // fresh brush, then use it straight away
                    define_brush(slot, pick_side(), pick_side(), -1);
                    stamp_at(slot, pick_origin(cfg_w), pick_origin(cfg_h),
                             $urandom_range(0, 255));
                end else if (pick < 74) begin
                    // stray row load, may change a slot's size under it
                    wd = random_word();
                    wd.op = OP_ROW;
                    wd.sw = SIZE_W'(pick_side());
                    wd.sh = SIZE_W'(pick_side());
                    push_word(wd);
                end else if (pick < 88) begin
                    wd = random_word();
                    wd.op = OP_MASK;
                    push_word(wd);
                end else begin
                    wd = random_word();
                    wd.op = OP_UNUSED;
                    push_word(wd);
                end
            end
        end
        calm = 1'b0;

        // drain, then leave room for any stray word the block might still send
        settle();
        repeat (80) @(posedge aclk);

        $display("covered %0d input words: %0d stamps, %0d loads, %0d unknown, %0d settings",
                 words_sent, stamps_sent, loads_sent, unknown_sent, settings_used);
        $display("checked %0d result words, %0d of them pixel writes, %0d faults",
                 words_checked, pixel_writes, fault_count);
        if (fault_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d result words still awaited", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== masked_brush_stamp_top.f =====
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_front.sv
hw/rtl/mbs_queue.sv
hw/rtl/mbs_back.sv
hw/rtl/masked_brush_stamp_top.sv
hw/rtl/mbs_checker.sv
tb/mbs_checker.sv
tb/masked_brush_stamp_top_tb.sv
